// File: hdl/gbso_pkg.sv
// Package for the greedy-by-size offset planner.
// Holds field widths, table entry and gap accumulator types, op codes and FSM states.
// No dependencies.
package gbso_pkg;

  localparam int unsigned MAX_BUFFERS = 64;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned NODE_W      = 16;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned OFF_W       = 38;
  localparam int unsigned ACC_W       = OFF_W + 1;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PLAN   = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NODE_W-1:0] first;
    logic [NODE_W-1:0] last;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // One placed neighbour as seen against the buffer being placed.
  typedef struct packed {
    logic [NODE_W-1:0] cur_first;
    logic [NODE_W-1:0] cur_last;
    logic [SIZE_W-1:0] cur_size;
    logic [NODE_W-1:0] nb_first;
    logic [NODE_W-1:0] nb_last;
    logic [SIZE_W-1:0] nb_size;
    logic [OFF_W-1:0]  nb_off;
  } gap_in_t;

  // Running state of the gap search over placed buffers.
  typedef struct packed {
    logic [ACC_W-1:0] prev;
    logic [ACC_W-1:0] best;
    logic [ACC_W-1:0] smallest;
    logic             found;
  } gap_acc_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CHK,
    ST_LK_DONE,
    ST_SEL_RD,
    ST_SEL_CHK,
    ST_SEL_END,
    ST_PL_RDP,
    ST_PL_RDE,
    ST_PL_CHK,
    ST_PL_END,
    ST_IN_RDP,
    ST_IN_RDO,
    ST_IN_CHK,
    ST_OUT_RDO,
    ST_OUT_RDE,
    ST_OUT_LOAD
  } state_e;

endpackage

// File: hdl/greedy_by_size_offset_planner_top.sv
// Greedy-by-size offset planner, top level: buffer table, plan scratch, sequencer.
// Record/remove: one table scan per word, ending at a matching id or after the last slot.
// Plan: per buffer a selection scan over all slots, a pass over each placed neighbour
// through the shared gap unit, a placement step and an insertion step; then one word per buffer.
// Not ready while an item is in work; the output register frees the sink side.
// Reset clears valid marks, overflow flag and control at once; no clearing pass.
module greedy_by_size_offset_planner_top #(
  parameter int unsigned MAX_BUFFERS = gbso_pkg::MAX_BUFFERS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: tensor_id[15:0], node_index[31:16], tensor_size[63:32]
  input  logic [63:0] s_axis_tdata_i,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: result_id[15:0], result_offset[53:16], total_bytes[91:54], zero pad [95:92]
  output logic [95:0] m_axis_tdata_o,
  // tuser: entry_valid[0], table_overflow[1]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned CW = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned OW = gbso_pkg::OFF_W;
  localparam int unsigned XW = gbso_pkg::ACC_W;

  // Memories: table entries, planned offsets, placement order, offset-sorted list
  gbso_pkg::entry_t ent_mem [MAX_BUFFERS];
  logic [OW-1:0]    off_mem [MAX_BUFFERS];
  logic [AW-1:0]    ord_mem [MAX_BUFFERS];
  logic [AW-1:0]    plc_mem [MAX_BUFFERS];

  logic ent_we, off_we, ord_we, plc_we;
  logic [AW-1:0] ent_waddr, off_waddr, ord_waddr, plc_waddr;
  logic [AW-1:0] ent_raddr, off_raddr, ord_raddr, plc_raddr;
  gbso_pkg::entry_t ent_wdata, ent_rdata;
  logic [OW-1:0] off_wdata, off_rdata;
  logic [AW-1:0] ord_wdata, ord_rdata, plc_wdata, plc_rdata;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (plc_we) begin
      plc_mem[plc_waddr] <= plc_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
    off_rdata <= off_mem[off_raddr];
    ord_rdata <= ord_mem[ord_raddr];
    plc_rdata <= plc_mem[plc_raddr];
  end

  gbso_pkg::state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, cnt_q, cnt_d;
  logic [1:0] op_q, op_d;
  gbso_pkg::entry_t in_q, in_d;
  logic hit_q, hit_d, free_q, free_d;
  logic [AW-1:0] hit_slot_q, hit_slot_d, free_slot_q, free_slot_d;
  gbso_pkg::entry_t hit_ent_q, hit_ent_d;
  logic have_prev_q, have_prev_d, best_found_q, best_found_d;
  gbso_pkg::entry_t prev_q, prev_d, best_q, best_d, cur_q, cur_d;
  logic [AW-1:0] best_slot_q, best_slot_d, cur_slot_q, cur_slot_d;
  gbso_pkg::gap_acc_t acc_q, acc_d, acc_step;
  gbso_pkg::gap_in_t nb;
  logic [OW-1:0] off_q, off_d;
  logic [XW-1:0] total_q, total_d, place_off, place_top;
  logic [MAX_BUFFERS-1:0] valid_q, valid_d;
  logic ovf_q, ovf_d;

  logic out_valid_q, out_valid_d, out_load;
  logic [gbso_pkg::ID_W-1:0] out_id_q, out_id_d;
  logic [OW-1:0] out_off_q, out_off_d, out_total_q, out_total_d;
  logic out_ev_q, out_ev_d, out_ovf_q, out_ovf_d, out_last_q, out_last_d;

  logic prev_first, cand_first, scan_end;
  logic [AW-1:0] i_idx;

  assign i_idx    = i_q[AW-1:0];
  assign scan_end = (i_q == CW'(MAX_BUFFERS - 1));

  // candidate must fall after the last selected buffer and before the best so far
  gbso_order_cmp u_cmp_prev (.a_i(prev_q),    .b_i(ent_rdata), .a_first_o(prev_first));
  gbso_order_cmp u_cmp_best (.a_i(ent_rdata), .b_i(best_q),    .a_first_o(cand_first));

  always_comb begin
    nb.cur_first = cur_q.first;
    nb.cur_last  = cur_q.last;
    nb.cur_size  = cur_q.size;
    nb.nb_first  = ent_rdata.first;
    nb.nb_last   = ent_rdata.last;
    nb.nb_size   = ent_rdata.size;
    nb.nb_off    = off_rdata;
  end

  gbso_gap_unit u_gap (.nb_i(nb), .acc_i(acc_q), .acc_o(acc_step));

  assign place_off = acc_q.found ? acc_q.best : acc_q.prev;
  assign place_top = place_off + {{(XW-gbso_pkg::SIZE_W){1'b0}}, cur_q.size};

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    in_d         = in_q;
    hit_d        = hit_q;
    free_d       = free_q;
    hit_slot_d   = hit_slot_q;
    free_slot_d  = free_slot_q;
    hit_ent_d    = hit_ent_q;
    have_prev_d  = have_prev_q;
    best_found_d = best_found_q;
    prev_d       = prev_q;
    best_d       = best_q;
    cur_d        = cur_q;
    best_slot_d  = best_slot_q;
    cur_slot_d   = cur_slot_q;
    acc_d        = acc_q;
    off_d        = off_q;
    total_d      = total_q;
    valid_d      = valid_q;
    ovf_d        = ovf_q;
    out_load     = 1'b0;
    out_id_d     = out_id_q;
    out_off_d    = out_off_q;
    out_total_d  = out_total_q;
    out_ev_d     = out_ev_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;

    ent_we = 1'b0; ent_waddr = i_idx; ent_wdata = in_q;
    off_we = 1'b0; off_waddr = cur_slot_q; off_wdata = place_off[OW-1:0];
    ord_we = 1'b0; ord_waddr = cnt_q[AW-1:0]; ord_wdata = best_slot_q;
    plc_we = 1'b0; plc_waddr = j_q[AW-1:0]; plc_wdata = cur_slot_q;

    ent_raddr = i_idx;
    off_raddr = plc_rdata;
    ord_raddr = j_q[AW-1:0];
    plc_raddr = j_q[AW-1:0];

    s_axis_tready_o = 1'b0;

    unique case (state_q)
      gbso_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tuser_i;
          in_d.id    = s_axis_tdata_i[15:0];
          in_d.first = s_axis_tdata_i[31:16];
          in_d.last  = s_axis_tdata_i[31:16];
          in_d.size  = s_axis_tdata_i[63:32];
          i_d = '0;
          priority case (s_axis_tuser_i)
            gbso_pkg::OP_RECORD, gbso_pkg::OP_REMOVE: begin
              hit_d   = 1'b0;
              free_d  = 1'b0;
              state_d = gbso_pkg::ST_LK_RD;
            end
            gbso_pkg::OP_PLAN: begin
              cnt_d        = '0;
              have_prev_d  = 1'b0;
              best_found_d = 1'b0;
              total_d      = '0;
              state_d      = gbso_pkg::ST_SEL_RD;
            end
            default: state_d = gbso_pkg::ST_IDLE;
          endcase
        end
      end

      gbso_pkg::ST_LK_RD: state_d = gbso_pkg::ST_LK_CHK;

      gbso_pkg::ST_LK_CHK: begin
        if (valid_q[i_idx] && ent_rdata.id == in_q.id) begin
          hit_d      = 1'b1;
          hit_slot_d = i_idx;
          hit_ent_d  = ent_rdata;
          state_d    = gbso_pkg::ST_LK_DONE;
        end else begin
          // remember the lowest free slot for an insert
          if (!valid_q[i_idx] && !free_q) begin
            free_d      = 1'b1;
            free_slot_d = i_idx;
          end
          if (scan_end) begin
            state_d = gbso_pkg::ST_LK_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = gbso_pkg::ST_LK_RD;
          end
        end
      end

      gbso_pkg::ST_LK_DONE: begin
        state_d = gbso_pkg::ST_IDLE;
        if (op_q == gbso_pkg::OP_RECORD) begin
          if (hit_q) begin
            ent_we          = 1'b1;
            ent_waddr       = hit_slot_q;
            ent_wdata       = hit_ent_q;
            ent_wdata.first = (hit_ent_q.first > in_q.first) ? in_q.first : hit_ent_q.first;
            ent_wdata.last  = (hit_ent_q.last < in_q.last) ? in_q.last : hit_ent_q.last;
          end else if (free_q) begin
            ent_we               = 1'b1;
            ent_waddr            = free_slot_q;
            valid_d[free_slot_q] = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else if (hit_q) begin
          valid_d[hit_slot_q] = 1'b0;
        end
      end

      gbso_pkg::ST_SEL_RD: state_d = gbso_pkg::ST_SEL_CHK;

      gbso_pkg::ST_SEL_CHK: begin
        if (valid_q[i_idx] && (!have_prev_q || prev_first) &&
            (!best_found_q || cand_first)) begin
          best_d       = ent_rdata;
          best_slot_d  = i_idx;
          best_found_d = 1'b1;
        end
        if (scan_end) begin
          state_d = gbso_pkg::ST_SEL_END;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = gbso_pkg::ST_SEL_RD;
        end
      end

      gbso_pkg::ST_SEL_END: begin
        j_d = '0;
        if (best_found_q) begin
          ord_we         = 1'b1;
          cur_d          = best_q;
          cur_slot_d     = best_slot_q;
          prev_d         = best_q;
          have_prev_d    = 1'b1;
          acc_d.prev     = '0;
          acc_d.best     = '0;
          acc_d.smallest = '0;
          acc_d.found    = 1'b0;
          state_d = (cnt_q == '0) ? gbso_pkg::ST_PL_END : gbso_pkg::ST_PL_RDP;
        end else begin
          state_d = (cnt_q == '0) ? gbso_pkg::ST_OUT_LOAD : gbso_pkg::ST_OUT_RDO;
        end
      end

      gbso_pkg::ST_PL_RDP: state_d = gbso_pkg::ST_PL_RDE;

      gbso_pkg::ST_PL_RDE: begin
        ent_raddr = plc_rdata;
        state_d   = gbso_pkg::ST_PL_CHK;
      end

      gbso_pkg::ST_PL_CHK: begin
        acc_d = acc_step;
        j_d   = j_q + 1'b1;
        state_d = (CW'(j_q + 1'b1) == cnt_q) ? gbso_pkg::ST_PL_END : gbso_pkg::ST_PL_RDP;
      end

      gbso_pkg::ST_PL_END: begin
        off_we = 1'b1;
        off_d  = place_off[OW-1:0];
        if (place_top > total_q) begin
          total_d = place_top;
        end
        j_d     = cnt_q;
        state_d = gbso_pkg::ST_IN_RDP;
      end

      gbso_pkg::ST_IN_RDP: begin
        plc_raddr = j_q[AW-1:0] - 1'b1;
        if (j_q == '0) begin
          plc_we       = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          i_d          = '0;
          best_found_d = 1'b0;
          state_d      = gbso_pkg::ST_SEL_RD;
        end else begin
          state_d = gbso_pkg::ST_IN_RDO;
        end
      end

      gbso_pkg::ST_IN_RDO: begin
        plc_raddr = j_q[AW-1:0] - 1'b1;
        state_d   = gbso_pkg::ST_IN_CHK;
      end

      gbso_pkg::ST_IN_CHK: begin
        plc_raddr = j_q[AW-1:0] - 1'b1;
        plc_we    = 1'b1;
        if (off_rdata > off_q) begin
          // shift the neighbour up one place
          plc_wdata = plc_rdata;
          j_d       = j_q - 1'b1;
          state_d   = gbso_pkg::ST_IN_RDP;
        end else begin
          cnt_d        = cnt_q + 1'b1;
          i_d          = '0;
          best_found_d = 1'b0;
          state_d      = gbso_pkg::ST_SEL_RD;
        end
      end

      gbso_pkg::ST_OUT_RDO: state_d = gbso_pkg::ST_OUT_RDE;

      gbso_pkg::ST_OUT_RDE: begin
        ent_raddr = ord_rdata;
        off_raddr = ord_rdata;
        state_d   = gbso_pkg::ST_OUT_LOAD;
      end

      gbso_pkg::ST_OUT_LOAD: begin
        // keep re-reading the same slot while the sink stalls
        ent_raddr = ord_rdata;
        off_raddr = ord_rdata;
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_ovf_d   = ovf_q;
          out_total_d = total_q[OW-1:0];
          if (cnt_q == '0) begin
            out_id_d   = '0;
            out_off_d  = '0;
            out_ev_d   = 1'b0;
            out_last_d = 1'b1;
            state_d    = gbso_pkg::ST_IDLE;
          end else begin
            out_id_d   = ent_rdata.id;
            out_off_d  = off_rdata;
            out_ev_d   = 1'b1;
            out_last_d = (CW'(j_q + 1'b1) == cnt_q);
            j_d        = j_q + 1'b1;
            state_d    = (CW'(j_q + 1'b1) == cnt_q) ? gbso_pkg::ST_IDLE
                                                    : gbso_pkg::ST_OUT_RDO;
          end
        end
      end

      default: state_d = gbso_pkg::ST_IDLE;
    endcase
  end

  // hold the word until the sink takes it
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gbso_pkg::ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      have_prev_q  <= 1'b0;
      best_found_q <= 1'b0;
      valid_q      <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      cnt_q        <= cnt_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      have_prev_q  <= have_prev_d;
      best_found_q <= best_found_d;
      valid_q      <= valid_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    in_q        <= in_d;
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    hit_ent_q   <= hit_ent_d;
    prev_q      <= prev_d;
    best_q      <= best_d;
    cur_q       <= cur_d;
    best_slot_q <= best_slot_d;
    cur_slot_q  <= cur_slot_d;
    acc_q       <= acc_d;
    off_q       <= off_d;
    total_q     <= total_d;
    out_id_q    <= out_id_d;
    out_off_q   <= out_off_d;
    out_total_q <= out_total_d;
    out_ev_q    <= out_ev_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_total_q, out_off_q, out_id_q};
  assign m_axis_tuser_o  = {out_ovf_q, out_ev_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: hdl/gbso_order_cmp.sv
// Placement order compare: descending size, ties by ascending id.
// Depends on gbso_pkg.
module gbso_order_cmp (
  input  gbso_pkg::entry_t a_i,
  input  gbso_pkg::entry_t b_i,
  output logic             a_first_o
);

  always_comb begin
    if (a_i.size != b_i.size) begin
      a_first_o = (a_i.size > b_i.size);
    end else begin
      a_first_o = (a_i.id < b_i.id);
    end
  end

endmodule

// File: hdl/gbso_gap_unit.sv
// Shared gap step: folds one placed neighbour into the gap search.
// Depends on gbso_pkg.
module gbso_gap_unit (
  input  gbso_pkg::gap_in_t  nb_i,
  input  gbso_pkg::gap_acc_t acc_i,
  output gbso_pkg::gap_acc_t acc_o
);

  logic [gbso_pkg::NODE_W-1:0] lo;
  logic [gbso_pkg::NODE_W-1:0] hi;
  logic [gbso_pkg::ACC_W-1:0]  aoff;
  logic [gbso_pkg::ACC_W-1:0]  gap;
  logic [gbso_pkg::ACC_W-1:0]  top;
  logic [gbso_pkg::ACC_W-1:0]  need;

  always_comb begin
    lo   = (nb_i.cur_first > nb_i.nb_first) ? nb_i.cur_first : nb_i.nb_first;
    hi   = (nb_i.cur_last < nb_i.nb_last) ? nb_i.cur_last : nb_i.nb_last;
    aoff = {1'b0, nb_i.nb_off};
    gap  = aoff - acc_i.prev;
    need = {{(gbso_pkg::ACC_W-gbso_pkg::SIZE_W){1'b0}}, nb_i.cur_size};
    top  = aoff + {{(gbso_pkg::ACC_W-gbso_pkg::SIZE_W){1'b0}}, nb_i.nb_size};
    acc_o = acc_i;
    // skip neighbours whose lives do not overlap
    if (lo <= hi) begin
      if (aoff > acc_i.prev && gap >= need && (!acc_i.found || gap < acc_i.smallest)) begin
        acc_o.smallest = gap;
        acc_o.best     = acc_i.prev;
        acc_o.found    = 1'b1;
      end
      if (top > acc_i.prev) begin
        acc_o.prev = top;
      end
    end
  end

endmodule
